@@ rtl/sbg_pkg.sv @@
// ----------------------------------------------------------------------------
// sbg_pkg
// Types, constants and the color gradient table of the bar-graph renderer.
// ----------------------------------------------------------------------------
package sbg_pkg;

   localparam int MAG_W   = 31;
   localparam int SHIFT_W = 5;
   localparam int COL_W   = 5;
   localparam int ROW_W   = 5;
   localparam int ADDR_W  = 10;
   localparam int COLOR_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_SHIFT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAR_STYLE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_SCHEME = 2'd2;

   // bar styles
   localparam logic [1:0] STYLE_SOLID  = 2'd0;
   localparam logic [1:0] STYLE_VSPLIT = 2'd1;
   localparam logic [1:0] STYLE_HSPLIT = 2'd2;
   localparam logic [1:0] STYLE_WIDE   = 2'd3;

   localparam logic [2:0] SCHEME_COLORFUL = 3'd6;

   localparam logic [15:0] RED = 16'hf800;
   localparam logic [15:0] YEL = 16'hffe0;
   localparam logic [15:0] BLU = 16'h001f;
   localparam logic [15:0] GRN = 16'h07e0;

   typedef struct packed {
      logic [SHIFT_W-1:0] magnitude_shift;
      logic [1:0]         bar_style;
      logic [2:0]         color_scheme;
   } cfg_type;

   typedef struct packed {
      logic load;     // request accepted
      logic advance;  // pixel write taken
   } cmd_type;

   typedef struct packed {
      logic draw;     // accepted request produces writes
      logic last;     // current write is the final one of the bar
   } status_type;

   localparam logic [COLOR_W-1:0] GRADIENT [7][32] = '{
      '{16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d,
        16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d,
        16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d,
        16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d, 16'hef7d},
      '{16'hef7d, 16'he75d, 16'he75d, 16'hdf5d, 16'hdf5d, 16'hd73d, 16'hd73d, 16'hcf3d,
        16'hcf3d, 16'hc71d, 16'hc71d, 16'hc71d, 16'hbf1d, 16'hbf1d, 16'hb6fd, 16'hb6fd,
        16'haefe, 16'haefe, 16'ha6de, 16'ha6de, 16'h9ede, 16'h9ede, 16'h9ede, 16'h96be,
        16'h96be, 16'h8ebe, 16'h8ebe, 16'h869e, 16'h869e, 16'h7e9e, 16'h7e9e, 16'h7e9f},
      '{16'hef7d, 16'hef7c, 16'hef7b, 16'hef7a, 16'hef79, 16'hef78, 16'hef77, 16'hef76,
        16'hef95, 16'hef94, 16'hef93, 16'hef92, 16'hef91, 16'hef90, 16'hef8f, 16'hef8e,
        16'hf7ae, 16'hf7ad, 16'hf7ac, 16'hf7ab, 16'hf7aa, 16'hf7a9, 16'hf7a8, 16'hf7a7,
        16'hf7c6, 16'hf7c5, 16'hf7c4, 16'hf7c3, 16'hf7c2, 16'hf7c1, 16'hf7c0, 16'hffe0},
      '{16'hef7d, 16'he77c, 16'hdf7b, 16'hd77a, 16'hcf79, 16'hc778, 16'hbf77, 16'hb776,
        16'haf95, 16'ha794, 16'h9f93, 16'h9792, 16'h8f91, 16'h8790, 16'h7f8f, 16'h778e,
        16'h77ae, 16'h6fad, 16'h67ac, 16'h5fab, 16'h57aa, 16'h4fa9, 16'h47a8, 16'h3fa7,
        16'h37c6, 16'h2fc5, 16'h27c4, 16'h1fc3, 16'h17c2, 16'h0fc1, 16'h07c0, 16'h07e0},
      '{16'hef7d, 16'hef3c, 16'heefb, 16'heeba, 16'hee79, 16'hee38, 16'hedf7, 16'hedb6,
        16'hed75, 16'hed34, 16'hecf3, 16'hecd2, 16'hec91, 16'hec50, 16'hec0f, 16'hebce,
        16'hf38e, 16'hf34d, 16'hf30c, 16'hf2cb, 16'hf28a, 16'hf269, 16'hf228, 16'hf1e7,
        16'hf1a6, 16'hf165, 16'hf124, 16'hf0e3, 16'hf0a2, 16'hf061, 16'hf020, 16'hf800},
      '{16'hef7d, 16'he73c, 16'hdefb, 16'hd6ba, 16'hce79, 16'hc638, 16'hbdf7, 16'hb5b6,
        16'had75, 16'ha534, 16'h9cf3, 16'h94d2, 16'h8c91, 16'h8450, 16'h7c0f, 16'h73ce,
        16'h738e, 16'h6b4d, 16'h630c, 16'h5acb, 16'h528a, 16'h4a69, 16'h4228, 16'h39e7,
        16'h31a6, 16'h2965, 16'h2124, 16'h18e3, 16'h10a2, 16'h0861, 16'h0020, 16'h0000},
      '{RED, YEL, BLU, BLU, GRN, GRN, RED, RED, YEL, YEL, BLU, BLU, GRN, GRN, RED, RED,
        RED, YEL, BLU, BLU, GRN, GRN, RED, RED, YEL, YEL, BLU, BLU, GRN, GRN, RED, RED}
   };

   // unused scheme code falls back to the colorful row
   function automatic logic [COLOR_W-1:0] gradient_color(input logic [2:0] scheme,
                                                         input logic [ROW_W-1:0] row);
      logic [2:0] sel;
      sel = (scheme > SCHEME_COLORFUL) ? SCHEME_COLORFUL : scheme;
      return GRADIENT[sel][row];
   endfunction

endpackage

@@ rtl/spectrum_bar_graph_renderer_core.sv @@
// The first pixel write is offered in the cycle after a request is accepted.
// A new request is taken only after the final pixel write (0..62 writes) of a bar;
//   the pixel walker emits one write per cycle while rsp_ready holds high.
// A request that draws nothing leaves the block ready for the next request.
// Reset: synchronous, active high; clears the bin counter and hold register and
//   loads the register defaults (shift 22, solid style, white scheme).
// ----------------------------------------------------------------------------
// spectrum_bar_graph_renderer_core
// Turns spectrum magnitude bins into pixel writes of a 32x32 RGB565 bar graph.
// ----------------------------------------------------------------------------
module spectrum_bar_graph_renderer_core
   import sbg_pkg::*;
#(
   parameter int BAR_COUNT  = 32,
   parameter int BAR_HEIGHT = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MAG_W-1:0]      req_magnitude,
   input  logic                  req_frame_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ADDR_W-1:0]     rsp_pixel_address,
   output logic [COLOR_W-1:0]    rsp_pixel_color,
   output logic                  rsp_run_last
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   sbg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sbg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sbg_datapath #(
      .BAR_COUNT  (BAR_COUNT),
      .BAR_HEIGHT (BAR_HEIGHT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_magnitude     (req_magnitude),
      .req_frame_end     (req_frame_end),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

@@ rtl/sbg_csr.sv @@
// ----------------------------------------------------------------------------
// sbg_csr
// Configuration registers: magnitude shift, bar style and color scheme.
// ----------------------------------------------------------------------------
module sbg_csr
   import sbg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAG_SHIFT:    cfg_in.magnitude_shift = csr_data;
            CSR_BAR_STYLE:    cfg_in.bar_style       = csr_data[1:0];
            CSR_COLOR_SCHEME: cfg_in.color_scheme    = csr_data[2:0];
            default:          cfg_in = cfg_ff;  // drop writes beyond the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magnitude_shift <= SHIFT_W'(22);
         cfg_ff.bar_style       <= STYLE_SOLID;
         cfg_ff.color_scheme    <= 3'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/sbg_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbg_ctrl
// Controller: takes one request, then walks its pixel writes to the end.
// ----------------------------------------------------------------------------
module sbg_ctrl
   import sbg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff, state_in;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = (state_ff == ST_EMIT);
   assign cmd.load    = req_valid && req_ready;
   assign cmd.advance = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (cmd.load && status.draw) state_in = ST_EMIT;
         ST_EMIT: if (cmd.advance && status.last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/sbg_datapath.sv @@
// ----------------------------------------------------------------------------
// sbg_datapath
// Bin counter, pair hold register, bar height and the row/column walker.
// ----------------------------------------------------------------------------
module sbg_datapath
   import sbg_pkg::*;
#(
   parameter int BAR_COUNT  = 32,
   parameter int BAR_HEIGHT = 32
)
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [MAG_W-1:0]   req_magnitude,
   input  logic               req_frame_end,
   output logic [ADDR_W-1:0]  rsp_pixel_address,
   output logic [COLOR_W-1:0] rsp_pixel_color,
   output logic               rsp_run_last
);

   localparam logic [MAG_W-1:0] TOP_ROW  = MAG_W'(BAR_HEIGHT - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(BAR_COUNT - 1);

   logic [COL_W-1:0] bin_counter_ff, bin_counter_in;
   logic [MAG_W-1:0] held_ff;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] height_ff, row_ff;
   logic             pair_ff, stride2_ff, left_ff;

   logic [MAG_W-1:0] shifted, bar_value;
   logic [MAG_W:0]   sum;
   logic [ROW_W-1:0] height;
   logic             odd, single, pair;
   logic [ROW_W:0]   row_next;
   logic [COL_W-1:0] col_out;

   assign shifted = req_magnitude >> cfg.magnitude_shift;
   assign sum     = {1'b0, held_ff} + {1'b0, shifted};
   assign odd     = bin_counter_ff[0];
   assign single  = (cfg.bar_style == STYLE_SOLID) ||
                    ((cfg.bar_style == STYLE_VSPLIT) && !odd);
   assign pair    = ((cfg.bar_style == STYLE_HSPLIT) || (cfg.bar_style == STYLE_WIDE)) && odd;
   assign bar_value = pair ? sum[MAG_W:1] : shifted;
   assign height    = (bar_value > TOP_ROW) ? ROW_W'(TOP_ROW) : bar_value[ROW_W-1:0];

   assign status.draw = (single || pair) && (height != '0);

   assign row_next    = {1'b0, row_ff} + (stride2_ff ? (ROW_W+1)'(2) : (ROW_W+1)'(1));
   assign status.last = !left_ff && (row_next >= {1'b0, height_ff});

   assign bin_counter_in = (req_frame_end || bin_counter_ff >= LAST_COL) ?
                           '0 : bin_counter_ff + COL_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_counter_ff <= '0;
         held_ff        <= '0;
      end else if (cmd.load) begin
         bin_counter_ff <= bin_counter_in;
         if (!odd) held_ff <= shifted;  // even bins always store
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff     <= bin_counter_ff;
         height_ff  <= height;
         pair_ff    <= pair;
         stride2_ff <= pair && (cfg.bar_style == STYLE_HSPLIT);
         left_ff    <= pair;
         row_ff     <= '0;
      end else if (cmd.advance) begin
         if (left_ff) begin
            left_ff <= 1'b0;  // right pixel of the same row next
         end else begin
            row_ff  <= row_next[ROW_W-1:0];
            left_ff <= pair_ff;
         end
      end
   end

   assign col_out           = left_ff ? col_ff - COL_W'(1) : col_ff;
   assign rsp_pixel_address = {ROW_W'(BAR_HEIGHT - 1) - row_ff, col_out};
   assign rsp_pixel_color   = gradient_color(cfg.color_scheme, row_ff);
   assign rsp_run_last      = status.last;

endmodule

@@ rtl/sbg_checker.sv @@
// ----------------------------------------------------------------------------
// sbg_checker
// Port-level checks of the renderer, bound to the top level.
// ----------------------------------------------------------------------------
module sbg_checker
   import sbg_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ADDR_W-1:0] rsp_pixel_address,
   input logic              rsp_run_last
);

   // no new request while a bar is still being written
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while pixel writes pending");

   // a bar continues until its final write
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_run_last) |=> rsp_valid)
      else $error("pixel run ended without final write");

   // final write returns the block to idle
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_run_last) |=> (!rsp_valid && req_ready))
      else $error("pixel write after final write");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel_address)))
      else $error("stalled pixel write changed");

endmodule

bind spectrum_bar_graph_renderer_core sbg_checker u_sbg_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_pixel_address (rsp_pixel_address),
   .rsp_run_last      (rsp_run_last)
);

@@ tb/sv/spectrum_bar_graph_renderer_core_tb.sv @@
// ----------------------------------------------------------------------------
// spectrum_bar_graph_renderer_core_tb
// Drives magnitude bins into the bar-graph renderer under every bar style,
// with directed and random shifts and color schemes. A behavioral scoreboard in
// the bench predicts each pixel write, and the monitor compares every write with
// that prediction. Both channels idle in random bursts in the random passes, except in quiet passes and at the end.
// ----------------------------------------------------------------------------
module spectrum_bar_graph_renderer_core_tb
   import sbg_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOP_ROW       = 31;
   localparam int ROW_PITCH     = 32;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 8;
   localparam int BINS_PER_PASS = 27;
   localparam int RANDOM_PASSES = 12;
   localparam longint CYCLE_LIMIT = 1_000_000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [1:0] STYLE_ORDER [4] = '{STYLE_SOLID, STYLE_VSPLIT,
                                               STYLE_HSPLIT, STYLE_WIDE};

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic             frame_end;
   } bin_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [MAG_W-1:0]      req_magnitude = '0;
   logic                  req_frame_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ADDR_W-1:0]     rsp_pixel_address;
   logic [COLOR_W-1:0]    rsp_pixel_color;
   logic                  rsp_run_last;

   // scoreboard state
   cfg_type          shadow_cfg = '{magnitude_shift: 5'd22, bar_style: STYLE_SOLID,
                                    color_scheme: 3'd0};
   logic [COL_W-1:0] bin_column = '0;
   logic [MAG_W-1:0] held_shifted = '0;

   bin_type   bin_q[$];
   pixel_type pixel_q[$];
   bin_type   next_bin;
   pixel_type want;

   bit     send_idle_on = 1'b0;
   bit     recv_idle_on = 1'b0;
   int     send_gap = 0;
   int     recv_stall = 0;
   int     mismatches = 0;
   longint cycles = 0;

   spectrum_bar_graph_renderer_core uut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_magnitude     (req_magnitude),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_run_last      (rsp_run_last)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int clip_height(longint value);
      return (value > TOP_ROW) ? TOP_ROW : int'(value);
   endfunction

   function automatic void add_pixel(logic [COL_W-1:0] col, int row, logic last);
      pixel_type  px;
      logic [2:0] scheme;
      scheme   = (shadow_cfg.color_scheme > SCHEME_COLORFUL) ? SCHEME_COLORFUL
                                                             : shadow_cfg.color_scheme;
      px.addr  = ADDR_W'(int'(col) + (TOP_ROW - row) * ROW_PITCH);
      px.color = GRADIENT[scheme][row];
      px.last  = last;
      pixel_q.push_back(px);
   endfunction

   // predict the pixel writes of one accepted bin and advance the column
   function automatic void render_bin(logic [MAG_W-1:0] magnitude, logic frame_end);
      logic [MAG_W-1:0] shifted;
      logic [MAG_W:0]   pair_sum;
      logic             odd;
      int               height;
      int               stride;
      shifted = magnitude >> shadow_cfg.magnitude_shift;
      odd     = bin_column[0];
      if (shadow_cfg.bar_style == STYLE_SOLID ||
          (shadow_cfg.bar_style == STYLE_VSPLIT && !odd)) begin
         height = clip_height(longint'(shifted));
         for (int row = 0; row < height; row++)
            add_pixel(bin_column, row, row == height - 1);
      end else if ((shadow_cfg.bar_style == STYLE_HSPLIT ||
                    shadow_cfg.bar_style == STYLE_WIDE) && odd) begin
         // average at full width, then saturate
         pair_sum = {1'b0, held_shifted} + {1'b0, shifted};
         height   = clip_height(longint'(pair_sum >> 1));
         stride   = (shadow_cfg.bar_style == STYLE_HSPLIT) ? 2 : 1;
         for (int row = 0; row < height; row += stride) begin
            add_pixel(bin_column - 1'b1, row, 1'b0);
            add_pixel(bin_column, row, row + stride >= height);
         end
      end
      if (!odd)
         held_shifted = shifted;
      if (frame_end || bin_column == COL_W'(TOP_ROW))
         bin_column = '0;
      else
         bin_column = bin_column + 1'b1;
   endfunction

   function automatic logic [MAG_W-1:0] pick_magnitude(logic [SHIFT_W-1:0] shift);
      longint base;
      int     bar;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return MAG_W'($urandom());
         default: begin
            // aim at a chosen bar height, fill the bits that shift out
            bar  = $urandom_range(0, 40);
            base = (longint'(bar) << shift) |
                   (longint'($urandom()) & ((longint'(1) << shift) - 1));
            return MAG_W'(base);
         end
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            render_bin(req_magnitude, req_frame_end);
         if (req_valid && !req_ready) begin
            // hold until taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (bin_q.size() == 0) begin
            req_valid <= 1'b0;
         end else if (send_idle_on && $urandom_range(0, 3) == 0) begin
            send_gap = $urandom_range(0, 5);
            req_valid <= 1'b0;
         end else begin
            next_bin = bin_q.pop_front();
            req_valid     <= 1'b1;
            req_magnitude <= next_bin.magnitude;
            req_frame_end <= next_bin.frame_end;
         end
      end
   end

   // pixel write monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_q.size() == 0) begin
            $display("%0t: unexpected write addr %h color %h last %b", $time,
                     rsp_pixel_address, rsp_pixel_color, rsp_run_last);
            mismatches++;
         end else begin
            want = pixel_q.pop_front();
            if (rsp_pixel_address !== want.addr) begin
               $display("%0t: pixel_address expected %h actual %h", $time,
                        want.addr, rsp_pixel_address);
               mismatches++;
            end
            if (rsp_pixel_color !== want.color) begin
               $display("%0t: pixel_color expected %h actual %h", $time,
                        want.color, rsp_pixel_color);
               mismatches++;
            end
            if (rsp_run_last !== want.last) begin
               $display("%0t: run_last expected %b actual %b", $time,
                        want.last, rsp_run_last);
               mismatches++;
            end
         end
      end
      if (recv_stall > 0) begin
         recv_stall--;
         rsp_ready <= 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
         recv_stall = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic void push_bin(logic [MAG_W-1:0] magnitude, logic frame_end);
      bin_q.push_back('{magnitude: magnitude, frame_end: frame_end});
   endfunction

   // wait until every request is taken and every write has come back
   task automatic drain();
      while (bin_q.size() != 0 || req_valid || pixel_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // call at a rising edge with csr_valid either low or just accepted
   task automatic csr_write(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_MAG_SHIFT:    shadow_cfg.magnitude_shift = data;
         CSR_BAR_STYLE:    shadow_cfg.bar_style = data[1:0];
         CSR_COLOR_SCHEME: shadow_cfg.color_scheme = data[2:0];
         default: ;
      endcase
   endtask

   task automatic program_block(logic [SHIFT_W-1:0] shift, logic [1:0] style,
                                logic [2:0] scheme);
      csr_write(CSR_MAG_SHIFT, shift);
      csr_write(CSR_BAR_STYLE, {3'($urandom()), style});
      if ($urandom_range(0, 2) == 0)
         csr_write(CSR_UNUSED, CSR_DATA_W'($urandom()));
      csr_write(CSR_COLOR_SCHEME, {2'($urandom()), scheme});
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [SHIFT_W-1:0] shift;
      int                 end_rate;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: zero height, saturation, single row, frame restart
      push_bin(31'd0, 1'b0);
      push_bin('1, 1'b0);
      push_bin(31'd1 << 22, 1'b0);
      push_bin(31'd3 << 22, 1'b1);
      drain();

      // vertical split with the unused scheme code
      program_block(5'd0, STYLE_VSPLIT, 3'd7);
      push_bin(31'd31, 1'b0);
      push_bin(31'd5, 1'b0);
      push_bin('1, 1'b1);
      drain();

      // largest shift leaves every bar empty
      program_block(5'd31, STYLE_HSPLIT, SCHEME_COLORFUL);
      push_bin('1, 1'b0);
      push_bin('1, 1'b0);
      drain();

      // full-height wide pair, then an even bin that the next style pairs with
      program_block(5'd1, STYLE_WIDE, 3'd1);
      push_bin('1, 1'b0);
      push_bin('1, 1'b0);
      push_bin(31'd40, 1'b0);
      drain();

      program_block(5'd1, STYLE_HSPLIT, 3'd5);
      push_bin(31'd24, 1'b0);
      push_bin(31'd4, 1'b0);
      push_bin(31'd3, 1'b1);
      drain();

      for (int pass = 0; pass < RANDOM_PASSES; pass++) begin
         case (pass)
            0: shift = 5'd0;
            1: shift = 5'd31;
            default: shift = SHIFT_W'($urandom_range(0, 31));
         endcase
         program_block(shift, STYLE_ORDER[pass % 4], 3'($urandom_range(0, 7)));
         // quiet passes in the middle and at the end
         send_idle_on = !(pass == 3 || pass == 6 || pass >= RANDOM_PASSES - 2);
         recv_idle_on = !(pass == 5 || pass == 6 || pass >= RANDOM_PASSES - 2);
         // rare frame ends let the column wrap on its own
         end_rate = (pass % 2 == 0) ? 8 : 60;
         for (int k = 0; k < BINS_PER_PASS; k++)
            push_bin(pick_magnitude(shift), $urandom_range(1, end_rate) == 1);
         drain();
      end

      repeat (END_CYCLES) @(posedge clock);
      if (mismatches == 0 && pixel_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/sbg_pkg.sv
rtl/sbg_csr.sv
rtl/sbg_ctrl.sv
rtl/sbg_datapath.sv
rtl/spectrum_bar_graph_renderer_core.sv
rtl/sbg_checker.sv
tb/sv/spectrum_bar_graph_renderer_core_tb.sv
